/* hw/rtl/vmt_pkg.sv */
// Shared constants and command codes of the vertex transform engine.
`default_nettype none
package vmt_pkg;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int VEC_N          = 4;
	localparam int IDX_W          = 2;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_XFORM = 1'b1
	} cmd_t;

	// Pipeline advance enables handed from the control in the top level to each lane.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} adv_t;
endpackage
`default_nettype wire

/* hw/rtl/vmt_in_if.sv */
// Request channel: matrix entry loads and vectors to transform.
`default_nettype none
interface vmt_in_if #(
	parameter int W = vmt_pkg::WORD_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic                           command;
	logic [vmt_pkg::IDX_W-1:0]      row_index;
	logic [vmt_pkg::IDX_W-1:0]      col_index;
	logic signed [W-1:0]            entry_value;
	logic signed [W-1:0]            vec_x;
	logic signed [W-1:0]            vec_y;
	logic signed [W-1:0]            vec_z;
	logic signed [W-1:0]            vec_w;

	modport source (output valid, command, row_index, col_index, entry_value,
		vec_x, vec_y, vec_z, vec_w, input ready);
	modport sink (input valid, command, row_index, col_index, entry_value,
		vec_x, vec_y, vec_z, vec_w, output ready);
endinterface
`default_nettype wire

/* hw/rtl/vmt_out_if.sv */
// Result channel: transformed vector and overflow flag.
`default_nettype none
interface vmt_out_if #(
	parameter int W = vmt_pkg::WORD_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] res_x;
	logic signed [W-1:0] res_y;
	logic signed [W-1:0] res_z;
	logic signed [W-1:0] res_w;
	logic                overflow;

	modport source (output valid, res_x, res_y, res_z, res_w, overflow, input ready);
	modport sink (input valid, res_x, res_y, res_z, res_w, overflow, output ready);
endinterface
`default_nettype wire

/* hw/rtl/vmt_matrix.sv */
// 4x4 matrix store, one entry written per load item, all entries read in parallel.
`default_nettype none
module vmt_matrix #(
	parameter int W = vmt_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [vmt_pkg::IDX_W-1:0] wr_row,
	input  wire logic [vmt_pkg::IDX_W-1:0] wr_col,
	input  wire logic signed [W-1:0]       wr_data,
	output logic signed [W-1:0]            entries [vmt_pkg::VEC_N][vmt_pkg::VEC_N]
);
	logic signed [W-1:0] mat_q [vmt_pkg::VEC_N][vmt_pkg::VEC_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < vmt_pkg::VEC_N; r++) begin
				for (int c = 0; c < vmt_pkg::VEC_N; c++) begin
					mat_q[r][c] <= '0;
				end
			end
		end else if (wr_en) begin
			mat_q[wr_row][wr_col] <= wr_data;
		end
	end

	assign entries = mat_q;
endmodule
`default_nettype wire

/* hw/rtl/vmt_lane.sv */
// One output component: four products, their sum, the fraction shift and saturation.
`default_nettype none
module vmt_lane #(
	parameter int W = vmt_pkg::WORD_WIDTH_DEF,
	parameter int F = vmt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire vmt_pkg::adv_t       adv,
	input  wire logic signed [W-1:0] vec [vmt_pkg::VEC_N],
	input  wire logic signed [W-1:0] col [vmt_pkg::VEC_N],
	output logic signed [W-1:0]      res_s3,
	output logic                     ovf_s3
);
	localparam int LO_W  = W / 2;
	localparam int HI_W  = W - LO_W;
	localparam int PL_W  = W + LO_W + 1;
	localparam int PH_W  = W + HI_W;
	localparam int SL_W  = PL_W + 2;
	localparam int SH_W  = PH_W + 2;
	localparam int ACC_W = (2 * W + 3 > F + W + 1) ? 2 * W + 3 : F + W + 1;
	localparam int UP_W  = ACC_W - (F + W - 1);

	logic signed [PL_W-1:0] plo_s1 [vmt_pkg::VEC_N];
	logic signed [PH_W-1:0] phi_s1 [vmt_pkg::VEC_N];
	logic signed [SL_W-1:0] slo_s2;
	logic signed [SH_W-1:0] shi_s2;
	logic signed [SL_W-1:0] slo;
	logic signed [SH_W-1:0] shi;
	logic signed [ACC_W-1:0] total;
	logic [UP_W-1:0]        upper;
	logic                   in_range;

	// Split each matrix entry into an unsigned low half and a signed high half.
	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			for (int i = 0; i < vmt_pkg::VEC_N; i++) begin
				plo_s1[i] <= PL_W'(vec[i]) * PL_W'($signed({1'b0, col[i][LO_W-1:0]}));
				phi_s1[i] <= PH_W'(vec[i]) * PH_W'($signed(col[i][W-1:LO_W]));
			end
		end
	end

	always_comb begin
		slo = (SL_W'(plo_s1[0]) + SL_W'(plo_s1[1])) + (SL_W'(plo_s1[2]) + SL_W'(plo_s1[3]));
		shi = (SH_W'(phi_s1[0]) + SH_W'(phi_s1[1])) + (SH_W'(phi_s1[2]) + SH_W'(phi_s1[3]));
	end

	always_ff @(posedge clk) begin
		if (adv.en_s2) begin
			slo_s2 <= slo;
			shi_s2 <= shi;
		end
	end

	// Recombine the halves; the kept word is total[F+W-1:F], floor of the shift.
	always_comb begin
		total    = (ACC_W'(shi_s2) <<< LO_W) + ACC_W'(slo_s2);
		upper    = total[ACC_W-1:F+W-1];
		in_range = (&upper) | ~(|upper);
	end

	always_ff @(posedge clk) begin
		if (adv.en_s3) begin
			ovf_s3 <= ~in_range;
			if (in_range) begin
				res_s3 <= total[F+W-1:F];
			end else if (total[ACC_W-1]) begin
				res_s3 <= {1'b1, {(W-1){1'b0}}};
			end else begin
				res_s3 <= {1'b0, {(W-1){1'b1}}};
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/vec4_matrix_transform.sv */
// Top level of the 4x4 homogeneous vertex transform engine.
// Takes one item per cycle unless a stalled output has filled the stages. A load item
// writes one matrix entry at its acceptance edge and yields nothing; a transform item
// computes res[j] = sum of v[i]*M[i][j] in signed fixed point, shifts right by FRAC_BITS
// (rounding toward minus infinity), saturates each component to WORD_WIDTH bits and
// flags overflow if any component saturated. A transform result passes the partial
// product stage, which loads at its acceptance edge, the sum and the recombine/saturate
// stages, then the output register that merges the four lanes. Stages advance
// independently, so bubbles close up and items are still taken while a finished result
// waits on a stalled output, until the stages fill. The matrix clears to zero at reset;
// a transform accepted in the cycle after a load already sees the new entry.
`default_nettype none
module vec4_matrix_transform #(
	parameter int WORD_WIDTH = vmt_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = vmt_pkg::FRAC_BITS_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	vmt_in_if.sink        req,
	vmt_out_if.source     rsp
);
	localparam int N = vmt_pkg::VEC_N;

	logic signed [WORD_WIDTH-1:0] entries [N][N];
	logic signed [WORD_WIDTH-1:0] vec [N];
	logic signed [WORD_WIDTH-1:0] res_l [N];
	logic [N-1:0]                 ovf_l;
	vmt_pkg::adv_t                adv;
	logic                         v_s1, v_s2, v_s3;
	logic                         out_adv;
	logic                         accept;
	logic                         is_load;

	assign out_adv    = ~rsp.valid | rsp.ready;
	assign adv.en_s3  = ~v_s3 | out_adv;
	assign adv.en_s2  = ~v_s2 | adv.en_s3;
	assign adv.en_s1  = ~v_s1 | adv.en_s2;
	assign req.ready  = adv.en_s1;
	assign accept     = req.valid & req.ready;
	assign is_load    = (req.command == vmt_pkg::CMD_LOAD);

	assign vec[0] = req.vec_x;
	assign vec[1] = req.vec_y;
	assign vec[2] = req.vec_z;
	assign vec[3] = req.vec_w;

	vmt_matrix #(.W(WORD_WIDTH)) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept & is_load),
		.wr_row  (req.row_index),
		.wr_col  (req.col_index),
		.wr_data (req.entry_value),
		.entries (entries)
	);

	for (genvar j = 0; j < N; j++) begin : g_lane
		logic signed [WORD_WIDTH-1:0] col [N];

		for (genvar i = 0; i < N; i++) begin : g_col
			assign col[i] = entries[i][j];
		end

		vmt_lane #(.W(WORD_WIDTH), .F(FRAC_BITS)) u_lane (
			.clk    (clk),
			.adv    (adv),
			.vec    (vec),
			.col    (col),
			.res_s3 (res_l[j]),
			.ovf_s3 (ovf_l[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			if (adv.en_s1) begin
				v_s1 <= accept & ~is_load;
			end
			if (adv.en_s2) begin
				v_s2 <= v_s1;
			end
			if (adv.en_s3) begin
				v_s3 <= v_s2;
			end
			if (out_adv) begin
				rsp.valid <= v_s3;
			end
		end
	end

	// Merge the lanes into the output register.
	always_ff @(posedge clk) begin
		if (out_adv) begin
			rsp.res_x    <= res_l[0];
			rsp.res_y    <= res_l[1];
			rsp.res_z    <= res_l[2];
			rsp.res_w    <= res_l[3];
			rsp.overflow <= |ovf_l;
		end
	end

	a_result_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(v_s3))
		else $error("result appeared without an item in the last lane stage");

	a_load_written: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_load) |=>
		entries[$past(req.row_index)][$past(req.col_index)] == $past(req.entry_value))
		else $error("load item did not reach the matrix store");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.overflow) |->
		(rsp.res_x == {1'b1, {(WORD_WIDTH-1){1'b0}}} || rsp.res_x == {1'b0, {(WORD_WIDTH-1){1'b1}}}
		|| rsp.res_y == {1'b1, {(WORD_WIDTH-1){1'b0}}} || rsp.res_y == {1'b0, {(WORD_WIDTH-1){1'b1}}}
		|| rsp.res_z == {1'b1, {(WORD_WIDTH-1){1'b0}}} || rsp.res_z == {1'b0, {(WORD_WIDTH-1){1'b1}}}
		|| rsp.res_w == {1'b1, {(WORD_WIDTH-1){1'b0}}} || rsp.res_w == {1'b0, {(WORD_WIDTH-1){1'b1}}}))
		else $error("overflow flagged with no saturated component");
endmodule
`default_nettype wire
